>>> src/assert_macros.svh
// assertion macros used by the converter top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`else

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> src/rhsl_pkg.sv
// shared types and constants of the rgb to hsl converter
`timescale 1ns / 1ps
`default_nettype none

package rhsl_pkg;

  // pixel channel and result field widths
  localparam int unsigned CH_W  = 8;
  localparam int unsigned HUE_W = 15;
  localparam int unsigned SL_W  = 13;

  // width of the hue dividend before scaling, up to 5 * 255
  localparam int unsigned M_W = 11;

  // quotient bits beyond FRAC_BITS, enough for 300 << FRAC_BITS
  localparam int unsigned QW_EXTRA = 9;

  // stream data widths
  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned OUT_DATA_W = 48;

  // divider lanes
  localparam int unsigned LANES    = 3;
  localparam int unsigned LANE_HUE = 0;
  localparam int unsigned LANE_SAT = 1;
  localparam int unsigned LANE_LIG = 2;

  // per-item flags that travel along the divider
  typedef struct packed {
    logic grey;     // max equals min
    logic hue_neg;  // red sector with green below blue
  } side_t;

endpackage

`default_nettype wire

>>> src/rhsl_front.sv
// front stages: channel extrema, differences and scaled dividends
`timescale 1ns / 1ps
`default_nettype none

module rhsl_front import rhsl_pkg::*; #(
  parameter int unsigned FRAC_BITS = 6,
  localparam int unsigned QW = FRAC_BITS + QW_EXTRA,
  localparam int unsigned NW = QW + CH_W
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  logic [CH_W-1:0]               red_i,
  input  logic [CH_W-1:0]               green_i,
  input  logic [CH_W-1:0]               blue_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output logic [LANES-1:0][NW-1:0]      num_o,
  output logic [LANES-1:0][CH_W-1:0]    den_o,
  output side_t                         side_o
);

  typedef enum logic [1:0] {
    SEC_RED   = 2'd0,
    SEC_GREEN = 2'd1,
    SEC_BLUE  = 2'd2
  } sector_e;

  localparam logic [NW-1:0] HUE_SCALE = NW'(60) << FRAC_BITS;
  localparam logic [NW-1:0] SAT_SCALE = NW'(100) << FRAC_BITS;
  localparam logic [NW-1:0] LIG_SCALE = NW'(50) << FRAC_BITS;
  localparam logic [CH_W:0] SUM_FULL  = (CH_W+1)'(510);
  localparam logic [CH_W:0] SUM_HALF  = (CH_W+1)'(255);
  localparam logic [CH_W-1:0] LIG_DEN = CH_W'(255);

  logic v1_q, v2_q, v3_q;
  logic en1, en2, en3;

  assign en3     = !v3_q || ready_i;
  assign en2     = !v2_q || en3;
  assign en1     = !v1_q || en2;
  assign ready_o = en1;
  assign valid_o = v3_q;

  // stage 1: extrema and sector
  logic [CH_W-1:0] mx_d, mn_d;
  sector_e         sec_d;
  logic [CH_W-1:0] r1_q, g1_q, b1_q, mx1_q, mn1_q;
  sector_e         sec1_q;

  always_comb begin
    mx_d = red_i;
    mn_d = red_i;
    if (green_i > mx_d) mx_d = green_i;
    if (blue_i > mx_d) mx_d = blue_i;
    if (green_i < mn_d) mn_d = green_i;
    if (blue_i < mn_d) mn_d = blue_i;
    if (red_i == mx_d) begin
      sec_d = SEC_RED;
    end else if (green_i == mx_d) begin
      sec_d = SEC_GREEN;
    end else begin
      sec_d = SEC_BLUE;
    end
  end

  // stage 2: range, sum, hue dividend, saturation divisor
  logic [CH_W-1:0] d_d;
  logic [CH_W:0]   sum_d;
  logic [CH_W:0]   far_d;
  logic [M_W-1:0]  m_d;
  logic            neg_d;
  logic [CH_W-1:0] den_d;
  logic [CH_W-1:0] d2_q, den2_q;
  logic [CH_W:0]   sum2_q;
  logic [M_W-1:0]  m2_q;
  side_t           side2_q;

  always_comb begin
    d_d   = mx1_q - mn1_q;
    sum_d = {1'b0, mx1_q} + {1'b0, mn1_q};
    far_d = SUM_FULL - sum_d;
    den_d = (sum_d < SUM_HALF) ? sum_d[CH_W-1:0] : far_d[CH_W-1:0];
    neg_d = 1'b0;
    case (sec1_q)
      SEC_RED: begin
        neg_d = g1_q < b1_q;
        m_d   = neg_d ? M_W'(b1_q - g1_q) : M_W'(g1_q - b1_q);
      end
      SEC_GREEN: begin
        // never negative, so modular arithmetic is exact
        m_d = M_W'({d_d, 1'b0}) + M_W'(b1_q) - M_W'(r1_q);
      end
      SEC_BLUE: begin
        m_d = M_W'({d_d, 2'b00}) + M_W'(r1_q) - M_W'(g1_q);
      end
      default: begin
        m_d = '0;
      end
    endcase
  end

  // stage 3: scaled dividends
  logic [LANES-1:0][NW-1:0]   num3_q;
  logic [LANES-1:0][CH_W-1:0] den3_q;
  side_t                      side3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      r1_q   <= red_i;
      g1_q   <= green_i;
      b1_q   <= blue_i;
      mx1_q  <= mx_d;
      mn1_q  <= mn_d;
      sec1_q <= sec_d;
    end
    if (en2) begin
      d2_q            <= d_d;
      sum2_q          <= sum_d;
      m2_q            <= m_d;
      den2_q          <= den_d;
      side2_q.grey    <= d_d == '0;
      side2_q.hue_neg <= neg_d;
    end
    if (en3) begin
      num3_q[LANE_HUE] <= HUE_SCALE * NW'(m2_q);
      num3_q[LANE_SAT] <= SAT_SCALE * NW'(d2_q);
      num3_q[LANE_LIG] <= LIG_SCALE * NW'(sum2_q);
      den3_q[LANE_HUE] <= d2_q;
      den3_q[LANE_SAT] <= den2_q;
      den3_q[LANE_LIG] <= LIG_DEN;
      side3_q          <= side2_q;
    end
  end

  assign num_o  = num3_q;
  assign den_o  = den3_q;
  assign side_o = side3_q;

endmodule

`default_nettype wire

>>> src/rhsl_div_pipe.sv
// pipelined restoring divider, one quotient bit per stage, all lanes in step
`timescale 1ns / 1ps
`default_nettype none

module rhsl_div_pipe import rhsl_pkg::*; #(
  parameter int unsigned FRAC_BITS = 6,
  localparam int unsigned QW = FRAC_BITS + QW_EXTRA,
  localparam int unsigned NW = QW + CH_W
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  logic [LANES-1:0][NW-1:0]      num_i,
  input  logic [LANES-1:0][CH_W-1:0]    den_i,
  input  side_t                         side_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output logic [LANES-1:0][QW-1:0]      quot_o,
  output side_t                         side_o
);

  // stage inputs; index 0 comes from the ports, index s+1 from register s
  logic [LANES-1:0][CH_W-1:0] rem_s  [QW+1];
  logic [LANES-1:0][QW-1:0]   word_s [QW+1];
  logic [LANES-1:0][CH_W-1:0] den_s  [QW+1];
  side_t                      side_s [QW+1];
  logic                       vld_s  [QW+1];
  logic                       adv    [QW+1];

  logic [LANES-1:0][CH_W-1:0] rem_q  [QW];
  logic [LANES-1:0][QW-1:0]   word_q [QW];
  logic [LANES-1:0][CH_W-1:0] den_q  [QW];
  side_t                      side_q [QW];
  logic                       vld_q  [QW];

  // the dividend's upper bits are below the divisor, so the quotient fits
  for (genvar l = 0; l < LANES; l++) begin : g_in
    assign rem_s[0][l]  = num_i[l][NW-1:QW];
    assign word_s[0][l] = num_i[l][QW-1:0];
  end
  assign den_s[0]  = den_i;
  assign side_s[0] = side_i;
  assign vld_s[0]  = valid_i;
  assign adv[QW]   = ready_i;

  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic [LANES-1:0][CH_W-1:0] rem_d;
    logic [LANES-1:0][QW-1:0]   word_d;

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [CH_W:0] trial;
      logic [CH_W:0] diff;
      logic          ge;

      assign trial = {rem_s[s][l], word_s[s][l][QW-1]};
      assign diff  = trial - {1'b0, den_s[s][l]};
      assign ge    = trial >= {1'b0, den_s[s][l]};
      assign rem_d[l]  = ge ? diff[CH_W-1:0] : trial[CH_W-1:0];
      assign word_d[l] = {word_s[s][l][QW-2:0], ge};
    end

    assign adv[s] = !vld_q[s] || adv[s+1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (adv[s]) begin
        vld_q[s] <= vld_s[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv[s]) begin
        rem_q[s]  <= rem_d;
        word_q[s] <= word_d;
        den_q[s]  <= den_s[s];
        side_q[s] <= side_s[s];
      end
    end

    assign rem_s[s+1]  = rem_q[s];
    assign word_s[s+1] = word_q[s];
    assign den_s[s+1]  = den_q[s];
    assign side_s[s+1] = side_q[s];
    assign vld_s[s+1]  = vld_q[s];
  end

  // final remainders are not needed
  assign ready_o = adv[0];
  assign valid_o = vld_s[QW];
  assign quot_o  = word_s[QW];
  assign side_o  = side_s[QW];

endmodule

`default_nettype wire

>>> src/rhsl_back.sv
// output stage: grey override, hue wrap and field masking
`timescale 1ns / 1ps
`default_nettype none

module rhsl_back import rhsl_pkg::*; #(
  parameter int unsigned FRAC_BITS = 6,
  localparam int unsigned QW = FRAC_BITS + QW_EXTRA,
  localparam int unsigned EXT_W = (QW > HUE_W) ? QW : HUE_W
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  output logic                        ready_o,
  input  logic [LANES-1:0][QW-1:0]    quot_i,
  input  side_t                       side_i,
  output logic                        valid_o,
  input  logic                        ready_i,
  output logic [HUE_W-1:0]            hue_o,
  output logic [SL_W-1:0]             sat_o,
  output logic [SL_W-1:0]             lig_o
);

  localparam logic [QW-1:0] HUE_TURN = QW'(360) << FRAC_BITS;

  logic [QW-1:0]    hue_full;
  logic [EXT_W-1:0] hue_ext, sat_ext, lig_ext;
  logic             valid_q;
  logic [HUE_W-1:0] hue_q;
  logic [SL_W-1:0]  sat_q, lig_q;
  logic             en;

  assign en = !valid_q || ready_i;

  always_comb begin
    hue_full = quot_i[LANE_HUE];
    // negative quotient wraps by a full turn; a zero stays zero
    if (side_i.hue_neg && (quot_i[LANE_HUE] != '0)) begin
      hue_full = HUE_TURN - quot_i[LANE_HUE];
    end
    if (side_i.grey) begin
      hue_full = '0;
    end
    hue_ext = EXT_W'(hue_full);
    sat_ext = side_i.grey ? '0 : EXT_W'(quot_i[LANE_SAT]);
    lig_ext = EXT_W'(quot_i[LANE_LIG]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hue_q <= hue_ext[HUE_W-1:0];
      sat_q <= sat_ext[SL_W-1:0];
      lig_q <= lig_ext[SL_W-1:0];
    end
  end

  assign ready_o = en;
  assign valid_o = valid_q;
  assign hue_o   = hue_q;
  assign sat_o   = sat_q;
  assign lig_o   = lig_q;

endmodule

`default_nettype wire

>>> src/rgb_to_hsl_converter_core.sv
// top level of the streaming rgb to hsl converter
// throughput: one pixel per cycle while the output is not stalled, set by the one-bit-per-stage divider pipeline
// stalls on the output hold every stage; bubbles close up before input is held off
// reset clears only the stage valid bits; data registers are not reset
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module rgb_to_hsl_converter_core import rhsl_pkg::*; #(
  parameter int unsigned FRAC_BITS = 6
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,  // red, green, blue
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o   // hue, saturation, lightness, zero pad
);

  localparam int unsigned QW = FRAC_BITS + QW_EXTRA;
  localparam int unsigned NW = QW + CH_W;
  localparam int unsigned PAD_W = OUT_DATA_W - HUE_W - 2 * SL_W;

  // front to divider
  logic                       fr_valid, fr_ready;
  logic [LANES-1:0][NW-1:0]   fr_num;
  logic [LANES-1:0][CH_W-1:0] fr_den;
  side_t                      fr_side;

  // divider to output stage
  logic                       dv_valid, dv_ready;
  logic [LANES-1:0][QW-1:0]   dv_quot;
  side_t                      dv_side;

  // result fields
  logic [HUE_W-1:0] hue;
  logic [SL_W-1:0]  saturation, lightness;

  // three stages: extrema, range and sum, constant-scaled dividends
  rhsl_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid_i),
    .ready_o (s_axis_tready_o),
    .red_i   (s_axis_tdata_i[CH_W-1:0]),
    .green_i (s_axis_tdata_i[2*CH_W-1:CH_W]),
    .blue_i  (s_axis_tdata_i[3*CH_W-1:2*CH_W]),
    .valid_o (fr_valid),
    .ready_i (fr_ready),
    .num_o   (fr_num),
    .den_o   (fr_den),
    .side_o  (fr_side)
  );

  // hue, saturation and lightness quotients side by side, FRAC_BITS + 9 stages
  rhsl_div_pipe #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fr_valid),
    .ready_o (fr_ready),
    .num_i   (fr_num),
    .den_i   (fr_den),
    .side_i  (fr_side),
    .valid_o (dv_valid),
    .ready_i (dv_ready),
    .quot_o  (dv_quot),
    .side_o  (dv_side)
  );

  // output register: grey override and hue wrap
  rhsl_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (dv_valid),
    .ready_o (dv_ready),
    .quot_i  (dv_quot),
    .side_i  (dv_side),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .hue_o   (hue),
    .sat_o   (saturation),
    .lig_o   (lightness)
  );

  assign m_axis_tdata_o = {{PAD_W{1'b0}}, lightness, saturation, hue};

  // field ranges hold wherever the scaling leaves them unmasked
  `ASSERT_IMPLY(a_hue_range, clk_i, rst_ni, m_axis_tvalid_o, (FRAC_BITS > 6) || (hue < HUE_W'(23040)))
  `ASSERT_IMPLY(a_sat_range, clk_i, rst_ni, m_axis_tvalid_o, (FRAC_BITS > 6) || (saturation <= SL_W'(6400)))
  `ASSERT_IMPLY(a_lig_range, clk_i, rst_ni, m_axis_tvalid_o, (FRAC_BITS > 6) || (lightness <= SL_W'(6400)))
  // input is held off only when the whole pipe is full behind a stalled result
  `ASSERT_IMPLY(a_stall_full, clk_i, rst_ni, !s_axis_tready_o, m_axis_tvalid_o && !m_axis_tready_i)
  // a stalled result stays valid and unchanged until it is taken
  `ASSERT_NEXT(a_stall_keeps, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o))

endmodule

`default_nettype wire
